/* src/aest_pkg.sv */
// Shared types and constants of the aging edge score table.
package aest_pkg;

    localparam logic [1:0] CMD_RESULT = 2'd0;
    localparam logic [1:0] CMD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] CFG_JOB_COUNT = 2'd0;
    localparam logic [1:0] CFG_WINDOW    = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_INTERVAL  = 2'd3;

    localparam logic [6:0]  JOB_COUNT_RESET = 7'd64;
    localparam logic [4:0]  WINDOW_RESET    = 5'd10;
    localparam logic [16:0] THRESHOLD_RESET = 17'd32768;
    localparam logic [16:0] ONE_Q16         = 17'd65536;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         source_job;
        logic [5:0]         target_job;
        logic               edge_permanent;
        logic signed [31:0] result_score;
        logic [31:0]        iteration_number;
    } in_t;

    typedef struct packed {
        logic [31:0] score_value;
        logic [16:0] adjustment;
        logic        bank_a_active;
    } out_t;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] score;
    } entry_t;

    typedef struct packed {
        entry_t b;
        entry_t a;
    } row_t;

endpackage

/* src/aest_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module aest_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/aest_div.sv */
// Restoring divider that retires one dividend bit per cycle.
module aest_div #(
    parameter int DVW = 40,
    parameter int DSW = 32,
    parameter int QW  = 17
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [QW-1:0]  quotient,
    output logic [DSW-1:0] remainder
);
    localparam int CW = $clog2(DVW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DVW-1:0] dvd_reg, dvd_next;
    logic [DSW-1:0] rem_reg, rem_next;
    logic [DSW-1:0] dsr_reg, dsr_next;
    logic [QW-1:0]  quo_reg, quo_next;
    logic [DSW:0]   trial;
    logic [DSW:0]   diff;
    logic           fits;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVW-1]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DSW-1:0] : trial[DSW-1:0];
            dvd_next = {dvd_reg[DVW-2:0], 1'b0};
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DVW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

/* src/aging_edge_score_table_top.sv */
// Top level of the aging edge score table: sequencer, score table and result window.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_data (in_t)
//   out       output     out_valid / out_ready out_data (out_t)
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// After reset a clearing pass writes all MAX_JOBS*MAX_JOBS table rows with in_ready low.
// An edge transaction does one table read-modify-write (none for a permanent edge), a
// query one table read, a tick a run of the divider (none with aging off) and a new result
// a walk of the window over the ring memory and a run of the bit-serial divider, if needed.
// An edge or query naming a job out of range skips the table. One transaction is in work
// at a time; a finished result waits in the output register while the next is accepted.
module aging_edge_score_table_top #(
    parameter int MAX_JOBS   = 64,
    parameter int MAX_WINDOW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  aest_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output aest_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import aest_pkg::*;

    localparam int JW     = $clog2(MAX_JOBS + 1);
    localparam int TDEPTH = MAX_JOBS * MAX_JOBS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int WW     = $clog2(MAX_WINDOW + 1);
    localparam int RW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RDEPTH = 1 << RW;
    localparam int BW     = WW + 17;
    localparam int DVW    = BW + 16;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_WIN_RD, S_WIN_CMP, S_BOUND, S_CHECK,
        S_DIV, S_RING_WR, S_TBL_USE, S_QSUM, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    in_t             item_reg, item_next;
    logic [TAW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [6:0]      job_count_reg, job_count_next;
    logic [4:0]      window_reg, window_next;
    logic [16:0]     thr_reg, thr_next;
    logic [31:0]     interval_reg, interval_next;
    logic [RW-1:0]   pos_reg, pos_next;
    logic [16:0]     adj_reg, adj_next;
    logic [31:0]     age_reg, age_next;
    logic            bank_reg, bank_next;
    logic [RDEPTH-1:0] ring_vld_reg, ring_vld_next;
    logic            vld_d_reg, vld_d_next;
    logic [WW-1:0]   win_cnt_reg, win_cnt_next;
    logic [WW-1:0]   better_reg, better_next;
    logic [BW-1:0]   bound_reg, bound_next;
    logic [31:0]     qsum_reg, qsum_next;
    logic [31:0]     value_reg, value_next;
    logic            out_valid_reg, out_valid_next;
    out_t            out_data_reg, out_data_next;

    logic [JW-1:0]   jc_eff;
    logic [WW-1:0]   w_eff;
    logic [16:0]     thr_eff;
    logic            pair_ok;
    logic [31:0]     idx_full;
    logic [TAW-1:0]  idx;
    logic [RW-1:0]   pos_use;
    logic [RW:0]     pos_inc;
    logic [WW+15:0]  better_sh;
    logic [BW-1:0]   num;
    logic [31:0]     elem;

    logic            tbl_we;
    logic [TAW-1:0]  tbl_waddr;
    row_t            tbl_wdata;
    row_t            tbl_rdata;
    entry_t          act_entry;
    entry_t          new_entry;
    logic [32:0]     sum_a;
    logic [32:0]     sum_b;
    logic [32:0]     sum_e;
    logic [31:0]     ring_rdata;

    logic            div_start;
    logic [DVW-1:0]  div_dividend;
    logic [31:0]     div_divisor;
    logic            div_done;
    logic [16:0]     div_quotient;
    logic [31:0]     div_remainder;

    aest_ram #(.WIDTH($bits(row_t)), .DEPTH(TDEPTH)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (idx),
        .rdata (tbl_rdata)
    );

    aest_ram #(.WIDTH(32), .DEPTH(RDEPTH)) u_ring (
        .clk   (clk),
        .we    (state_reg == S_RING_WR),
        .waddr (pos_use),
        .wdata (item_reg.result_score),
        .raddr (win_cnt_reg[RW-1:0]),
        .rdata (ring_rdata)
    );

    aest_div #(.DVW(DVW), .DSW(32), .QW(17)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb
    begin
        if (job_count_reg == 7'd0)
        begin
            jc_eff = JW'(1);
        end
        else if (32'(job_count_reg) > MAX_JOBS)
        begin
            jc_eff = JW'(MAX_JOBS);
        end
        else
        begin
            jc_eff = JW'(job_count_reg);
        end
        if (window_reg == 5'd0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(window_reg) > MAX_WINDOW)
        begin
            w_eff = WW'(MAX_WINDOW);
        end
        else
        begin
            w_eff = WW'(window_reg);
        end
        thr_eff  = (thr_reg > ONE_Q16) ? ONE_Q16 : thr_reg;
        pair_ok  = (32'(item_reg.source_job) < 32'(jc_eff)) &&
                   (32'(item_reg.target_job) < 32'(jc_eff));
        idx_full = 32'(item_reg.source_job) * 32'(jc_eff) + 32'(item_reg.target_job);
        idx      = idx_full[TAW-1:0];
        pos_use  = (32'(pos_reg) >= 32'(w_eff)) ? '0 : pos_reg;
        pos_inc  = {1'b0, pos_use} + (RW+1)'(1);
        better_sh = {better_reg, 16'd0};
        num      = bound_reg - BW'(better_sh);
        elem     = vld_d_reg ? ring_rdata : 32'd0;

        // Edge update of the active bank: a stale period restarts the entry.
        act_entry = bank_reg ? tbl_rdata.a : tbl_rdata.b;
        sum_e     = {1'b0, act_entry.score} + 33'(adj_reg);
        if (act_entry.period != age_reg)
        begin
            new_entry.period = age_reg;
            new_entry.score  = 32'(adj_reg);
        end
        else
        begin
            new_entry.period = act_entry.period;
            new_entry.score  = sum_e[32] ? 32'hFFFF_FFFF : sum_e[31:0];
        end

        sum_a = 33'(ONE_Q16) +
                ((tbl_rdata.a.period >= age_reg - 32'd1) ? 33'(tbl_rdata.a.score) : 33'd0);
        sum_b = {1'b0, qsum_reg} +
                ((tbl_rdata.b.period >= age_reg - 32'd1) ? 33'(tbl_rdata.b.score) : 33'd0);
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        clr_cnt_next   = clr_cnt_reg;
        job_count_next = job_count_reg;
        window_next    = window_reg;
        thr_next       = thr_reg;
        interval_next  = interval_reg;
        pos_next       = pos_reg;
        adj_next       = adj_reg;
        age_next       = age_reg;
        bank_next      = bank_reg;
        ring_vld_next  = ring_vld_reg;
        vld_d_next     = vld_d_reg;
        win_cnt_next   = win_cnt_reg;
        better_next    = better_reg;
        bound_next     = bound_reg;
        qsum_next      = qsum_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = idx;
        tbl_wdata      = bank_reg ? {tbl_rdata.b, new_entry} : {new_entry, tbl_rdata.a};
        div_start      = 1'b0;
        div_dividend   = DVW'(item_reg.iteration_number);
        div_divisor    = interval_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_JOB_COUNT: job_count_next = cfg_data[6:0];
                CFG_WINDOW:    window_next    = cfg_data[4:0];
                CFG_THRESHOLD: thr_next       = cfg_data[16:0];
                CFG_INTERVAL:  interval_next  = cfg_data;
                default:       ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                tbl_we       = 1'b1;
                tbl_waddr    = clr_cnt_reg;
                tbl_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + TAW'(1);
                if (clr_cnt_reg == TAW'(TDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                value_next = 32'd0;
                case (item_reg.command)
                    CMD_RESULT:
                    begin
                        win_cnt_next = '0;
                        better_next  = '0;
                        state_next   = S_WIN_RD;
                    end
                    CMD_EDGE:
                    begin
                        state_next = (item_reg.edge_permanent || !pair_ok) ? S_DONE : S_TBL_USE;
                    end
                    CMD_TICK:
                    begin
                        if (interval_reg == 32'd0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = pair_ok ? S_TBL_USE : S_DONE;
                    end
                endcase
            end
            S_WIN_RD:
            begin
                vld_d_next = ring_vld_reg[win_cnt_reg[RW-1:0]];
                state_next = S_WIN_CMP;
            end
            S_WIN_CMP:
            begin
                if ($signed(item_reg.result_score) >= $signed(elem))
                begin
                    better_next = better_reg + WW'(1);
                end
                win_cnt_next = win_cnt_reg + WW'(1);
                if (({1'b0, win_cnt_reg} + (WW+1)'(1)) == {1'b0, w_eff})
                begin
                    state_next = S_BOUND;
                end
                else
                begin
                    state_next = S_WIN_RD;
                end
            end
            S_BOUND:
            begin
                bound_next = BW'(32'(w_eff) * 32'(thr_eff));
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (BW'(better_sh) < bound_reg)
                begin
                    div_start    = 1'b1;
                    div_dividend = {num, 16'd0};
                    div_divisor  = 32'(bound_reg);
                    state_next   = S_DIV;
                end
                else
                begin
                    adj_next   = 17'd0;
                    state_next = S_RING_WR;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (item_reg.command == CMD_RESULT)
                    begin
                        adj_next   = div_quotient;
                        state_next = S_RING_WR;
                    end
                    else
                    begin
                        if (div_remainder == 32'd0)
                        begin
                            bank_next = !bank_reg;
                            age_next  = age_reg + 32'd1;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_RING_WR:
            begin
                ring_vld_next[pos_use] = 1'b1;
                pos_next   = (32'(pos_inc) >= 32'(w_eff)) ? '0 : pos_inc[RW-1:0];
                state_next = S_DONE;
            end
            S_TBL_USE:
            begin
                if (item_reg.command == CMD_EDGE)
                begin
                    tbl_we     = 1'b1;
                    state_next = S_DONE;
                end
                else if (interval_reg == 32'd0)
                begin
                    value_next = tbl_rdata.a.score;
                    state_next = S_DONE;
                end
                else
                begin
                    qsum_next  = sum_a[32] ? 32'hFFFF_FFFF : sum_a[31:0];
                    state_next = S_QSUM;
                end
            end
            S_QSUM:
            begin
                value_next = sum_b[32] ? 32'hFFFF_FFFF : sum_b[31:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.score_value   = value_reg;
                    out_data_next.adjustment    = adj_reg;
                    out_data_next.bank_a_active = bank_reg;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            item_reg      <= '0;
            clr_cnt_reg   <= '0;
            job_count_reg <= JOB_COUNT_RESET;
            window_reg    <= WINDOW_RESET;
            thr_reg       <= THRESHOLD_RESET;
            interval_reg  <= 32'd0;
            pos_reg       <= '0;
            adj_reg       <= 17'd0;
            age_reg       <= 32'd1;
            bank_reg      <= 1'b1;
            ring_vld_reg  <= '0;
            vld_d_reg     <= 1'b0;
            win_cnt_reg   <= '0;
            better_reg    <= '0;
            bound_reg     <= '0;
            qsum_reg      <= 32'd0;
            value_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            clr_cnt_reg   <= clr_cnt_next;
            job_count_reg <= job_count_next;
            window_reg    <= window_next;
            thr_reg       <= thr_next;
            interval_reg  <= interval_next;
            pos_reg       <= pos_next;
            adj_reg       <= adj_next;
            age_reg       <= age_next;
            bank_reg      <= bank_next;
            ring_vld_reg  <= ring_vld_next;
            vld_d_reg     <= vld_d_next;
            win_cnt_reg   <= win_cnt_next;
            better_reg    <= better_next;
            bound_reg     <= bound_next;
            qsum_reg      <= qsum_next;
            value_reg     <= value_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Only one transaction is in work, so acceptance must close the input side.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in work");

    // The adjustment moves only at the end of a window evaluation.
    a_adj_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(adj_reg) |-> ($past(state_reg) == S_CHECK || $past(state_reg) == S_DIV))
        else $error("adjustment changed outside a new-result transaction");

    // A bank swap always advances the period.
    a_swap_ages: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(bank_reg) |-> !$stable(age_reg))
        else $error("bank swapped without a period advance");
endmodule

/* verif/tb_aging_edge_score_table_top.sv */
// Self-checking testbench for the aging edge score table top level.
`timescale 1ns / 1ps

module tb_aging_edge_score_table_top;
    import aest_pkg::*;

    localparam int JOBS = 64;
    localparam int WIN = 16;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    aging_edge_score_table_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predicted copy of the block's state.
    logic [31:0] pa_period [JOBS*JOBS];
    logic [31:0] pa_score [JOBS*JOBS];
    logic [31:0] pb_period [JOBS*JOBS];
    logic [31:0] pb_score [JOBS*JOBS];
    logic signed [31:0] window_scores [WIN];
    int unsigned ring_pos;
    logic [16:0] cur_adj;
    logic [31:0] age_count;
    logic bank_a_sel;
    logic [6:0] reg_jobs;
    logic [4:0] reg_window;
    logic [16:0] reg_threshold;
    logic [31:0] reg_interval;

    out_t pending_results[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int idle_cycles = 0;
    bit hold_receiver = 0;
    bit stall_pattern_on = 1;

    initial begin
        clk = 0;
        forever
        begin
            #5 clk = 1;
            #5 clk = 0;
        end
    end

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int unsigned live_jobs();
        if (reg_jobs == 0) return 1;
        if (reg_jobs > JOBS) return JOBS;
        return reg_jobs;
    endfunction

    function automatic int unsigned live_window();
        if (reg_window == 0) return 1;
        if (reg_window > WIN) return WIN;
        return reg_window;
    endfunction

    task automatic clear_prediction();
        for (int i = 0; i < JOBS*JOBS; i++)
        begin
            pa_period[i] = 0; pa_score[i] = 0; pb_period[i] = 0; pb_score[i] = 0;
        end
        for (int i = 0; i < WIN; i++) window_scores[i] = 0;
        ring_pos = 0; cur_adj = 0; age_count = 1; bank_a_sel = 1;
        reg_jobs = JOB_COUNT_RESET; reg_window = WINDOW_RESET;
        reg_threshold = THRESHOLD_RESET; reg_interval = 0;
    endtask

    function automatic out_t score_table_predict(in_t it);
        out_t r;
        int unsigned w, jc, idx;
        longint unsigned bound, better;
        logic [31:0] thr, live;
        r = '0;
        case (it.command)
            CMD_RESULT:
            begin
                w = live_window();
                thr = (reg_threshold > ONE_Q16) ? 32'(ONE_Q16) : 32'(reg_threshold);
                bound = longint'(w) * thr;
                better = 0;
                for (int i = 0; i < w; i++)
                    if (it.result_score >= window_scores[i]) better++;
                if (better * 65536 < bound)
                    cur_adj = 17'(((bound - better * 65536) * 65536) / bound);
                else
                    cur_adj = 0;
                if (ring_pos >= w) ring_pos = 0;
                window_scores[ring_pos] = it.result_score;
                ring_pos++;
                if (ring_pos >= w) ring_pos = 0;
            end
            CMD_EDGE:
            begin
                jc = live_jobs();
                if (!it.edge_permanent && it.source_job < jc && it.target_job < jc)
                begin
                    idx = it.source_job * jc + it.target_job;
                    if (bank_a_sel)
                    begin
                        if (pa_period[idx] != age_count)
                        begin
                            pa_period[idx] = age_count; pa_score[idx] = cur_adj;
                        end
                        else pa_score[idx] = sat_sum(pa_score[idx], cur_adj);
                    end
                    else
                    begin
                        if (pb_period[idx] != age_count)
                        begin
                            pb_period[idx] = age_count; pb_score[idx] = cur_adj;
                        end
                        else pb_score[idx] = sat_sum(pb_score[idx], cur_adj);
                    end
                end
            end
            CMD_TICK:
            begin
                if (reg_interval != 0 && (it.iteration_number % reg_interval) == 0)
                begin
                    bank_a_sel = ~bank_a_sel;
                    age_count = age_count + 1;
                end
            end
            default:
            begin
                jc = live_jobs();
                if (it.source_job < jc && it.target_job < jc)
                begin
                    idx = it.source_job * jc + it.target_job;
                    if (reg_interval == 0) r.score_value = pa_score[idx];
                    else
                    begin
                        live = age_count - 1;
                        r.score_value = 32'd65536;
                        if (pa_period[idx] >= live)
                            r.score_value = sat_sum(r.score_value, pa_score[idx]);
                        if (pb_period[idx] >= live)
                            r.score_value = sat_sum(r.score_value, pb_score[idx]);
                    end
                end
            end
        endcase
        r.adjustment = cur_adj;
        r.bank_a_active = bank_a_sel;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h", checked, what, got, want);
        errors++;
    endtask

    // Sends one transaction and records its predicted result on acceptance.
    // Valid stays high afterwards so that transactions can follow back to back.
    task automatic send_item(in_t it);
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(score_table_predict(it));
        sent++;
    endtask

    // Random gaps between bursts.
    int burst_left = 0;
    task automatic send_paced(in_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_JOB_COUNT: reg_jobs = val[6:0];
            CFG_WINDOW: reg_window = val[4:0];
            CFG_THRESHOLD: reg_threshold = val[16:0];
            default: reg_interval = val;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic in_t make_item(logic [1:0] cmd, int unsigned s, int unsigned t);
        in_t it;
        it.command = cmd;
        it.source_job = 6'(s);
        it.target_job = 6'(t);
        it.edge_permanent = 1'b0;
        it.result_score = $urandom();
        it.iteration_number = $urandom();
        return it;
    endfunction

    function automatic in_t random_item(int unsigned jmax);
        in_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it = make_item(CMD_EDGE, $urandom_range(0, jmax), $urandom_range(0, jmax));
        if (pick < 20) it.command = CMD_RESULT;
        else if (pick < 60) it.command = CMD_EDGE;
        else if (pick < 72) it.command = CMD_TICK;
        else it.command = CMD_QUERY;
        it.edge_permanent = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 1)) it.result_score = $urandom_range(0, 40) - 20;
        if ($urandom_range(0, 1)) it.iteration_number = $urandom_range(0, 20);
        if ($urandom_range(0, 15) == 0)
        begin
            it.source_job = $urandom(); it.target_job = $urandom();
        end
        return it;
    endfunction

    task automatic test_defaults_directed();
        in_t it;
        it = make_item(CMD_QUERY, 0, 0); send_item(it);
        foreach (window_scores[i])
        begin
            it = make_item(CMD_RESULT, 0, 0);
            it.result_score = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            send_item(it);
        end
        it = make_item(CMD_EDGE, 63, 63); send_item(it);
        it = make_item(CMD_EDGE, 63, 63); send_item(it);
        it.edge_permanent = 1'b1; send_item(it);
        it = make_item(CMD_TICK, 0, 0); it.iteration_number = 0; send_item(it);
        it = make_item(CMD_QUERY, 63, 63); send_item(it);
        it = make_item(CMD_QUERY, 0, 63); send_item(it);
        drain();
    endtask

    task automatic test_config_extremes();
        in_t it;
        write_reg(CFG_JOB_COUNT, 0);
        write_reg(CFG_WINDOW, 0);
        write_reg(CFG_THRESHOLD, 32'h1FFFF);
        write_reg(CFG_INTERVAL, 1);
        it = make_item(CMD_RESULT, 0, 0); it.result_score = 32'sh8000_0000; send_item(it);
        it = make_item(CMD_EDGE, 0, 0); send_item(it);
        it = make_item(CMD_EDGE, 1, 0); send_item(it);
        it = make_item(CMD_TICK, 0, 0); it.iteration_number = 32'hFFFF_FFFF; send_item(it);
        it = make_item(CMD_QUERY, 0, 0); send_item(it);
        it = make_item(CMD_QUERY, 1, 1); send_item(it);
        drain();
        write_reg(CFG_JOB_COUNT, 127);
        write_reg(CFG_WINDOW, 31);
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
        it = make_item(CMD_RESULT, 0, 0); send_item(it);
        it = make_item(CMD_TICK, 0, 0); it.iteration_number = 32'hFFFF_FFFF; send_item(it);
        it = make_item(CMD_QUERY, 63, 0); send_item(it);
        drain();
    endtask

    // Shrinking the window leaves the ring position past its end.
    task automatic test_window_shrink();
        in_t it;
        write_reg(CFG_WINDOW, 16);
        write_reg(CFG_THRESHOLD, 65536);
        repeat (13)
        begin
            it = make_item(CMD_RESULT, 0, 0); send_item(it);
        end
        drain();
        write_reg(CFG_WINDOW, 3);
        repeat (4)
        begin
            it = make_item(CMD_RESULT, 0, 0); send_item(it);
        end
        drain();
    endtask

    // Sends only new results, with a window of one and the full threshold, so the adjustment reaches its largest value.
    task automatic test_saturation();
        in_t it;
        write_reg(CFG_JOB_COUNT, 2);
        write_reg(CFG_WINDOW, 1);
        write_reg(CFG_THRESHOLD, 65536);
        write_reg(CFG_INTERVAL, 0);
        it = make_item(CMD_RESULT, 0, 0); it.result_score = 32'sh8000_0000; send_item(it);
        it = make_item(CMD_RESULT, 0, 0); it.result_score = 32'sh8000_0000; send_item(it);
        it = make_item(CMD_RESULT, 0, 0); it.result_score = -5; send_item(it);
        repeat (10)
        begin
            it = make_item(CMD_RESULT, 0, 0); it.result_score = 32'sh8000_0000;
            send_item(it);
        end
        drain();
    endtask

    task automatic test_random_phase(int n, logic [6:0] jobs, logic [4:0] win,
                                     logic [16:0] thr, logic [31:0] intv);
        write_reg(CFG_JOB_COUNT, jobs);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_INTERVAL, intv);
        repeat (n) send_paced(random_item((jobs > 1 && jobs <= JOBS) ? jobs - 1 : 63));
        drain();
    endtask

    task automatic test_backpressure();
        in_t it;
        hold_receiver = 1;
        fork
        begin
            repeat (300) @(posedge clk);
            hold_receiver = 0;
        end
        repeat (8)
        begin
            it = random_item(7);
            send_item(it);
        end
        join
        drain();
    endtask

    // Receiver: a stall pattern of its own, always ready with the pattern off, or a long hold when asked.
    int stall_phase = 0;
    always @(posedge clk)
    begin
        stall_phase <= (stall_phase + 1) % 23;
        if (hold_receiver) out_ready <= 1'b0;
        else if (!stall_pattern_on) out_ready <= 1'b1;
        else out_ready <= (stall_phase < 14) ? 1'b1 : ($urandom_range(0, 2) == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            out_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", out_data.score_value, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.score_value !== want.score_value)
                    report_mismatch("score_value", out_data.score_value, want.score_value);
                if (out_data.adjustment !== want.adjustment)
                    report_mismatch("adjustment", 32'(out_data.adjustment),
                                    32'(want.adjustment));
                if (out_data.bank_a_active !== want.bank_a_active)
                    report_mismatch("bank_a_active", 32'(out_data.bank_a_active),
                                    32'(want.bank_a_active));
            end
            checked++;
        end
    end

    // Watchdog on cycles where no transaction moves; covers the clearing pass.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_receiver)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("** aging_edge_score_table_top: FAILED **");
            $finish;
        end
    end

    initial begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_ready = 0;
        cfg_we = 0;
        cfg_index = CFG_JOB_COUNT;
        cfg_data = 0;
        clear_prediction();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_defaults_directed();
        test_config_extremes();
        test_window_shrink();
        test_saturation();
        test_backpressure();
        test_random_phase(200, 8, 4, 49152, 0);
        test_random_phase(150, 4, 16, 65536, 3);
        stall_pattern_on = 0;
        test_random_phase(100, 64, 10, 32768, 2);
        stall_pattern_on = 1;
        test_random_phase(150, 3, 1, 20000, 1);
        $display("covered %0d transactions sent, %0d results checked, over", sent, checked);
        $display("default, extreme and random register settings with backpressure");
        if (errors == 0)
            $display("** aging_edge_score_table_top: PASSED **");
        else
            $display("** aging_edge_score_table_top: FAILED **");
        $finish;
    end

endmodule

/* files.f */
src/aest_pkg.sv
src/aest_ram.sv
src/aest_div.sv
src/aging_edge_score_table_top.sv
verif/tb_aging_edge_score_table_top.sv
